### hdl/crs_pkg.sv
package crs_pkg;

  // Table geometry and number formats
  localparam int MAX_POINTS  = 256;
  localparam int ADDR_W      = $clog2(MAX_POINTS);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int COORD_W     = 32;
  localparam int T_FRAC_BITS = 16;
  localparam int T_W         = T_FRAC_BITS + 1;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_EVAL   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                       op;
    logic [T_W-1:0]            t_frac;
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    status_t                   status;
  } out_t;

endpackage

### hdl/crs_ram.sv
module crs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/catmull_rom_spline_evaluator.sv
// Uniform Catmull-Rom evaluator over a table of 2-D control points; the receiver cannot stall.
// Append, and evaluate on an empty table: result strobe in the cycle after the transfer, busy low.
// Evaluate: busy in S_READ, S_LAST, S_M1, S_M2, S_M3, no command taken; result strobe after S_M3;
//   four point reads on the single memory port, then three dependent multiply-round steps.
// Reset (rst_n low, synchronous) empties the table and idles the sequencer; the point
//   memories keep their contents, entries are only read below the point count.
module catmull_rom_spline_evaluator
  import crs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  in_t  in_data,
  output logic busy,
  output logic out_valid,
  output out_t out_data
);

  // Internal arithmetic width: holds 3p1-3p2-p0+p3 and the partial sums of Horner's rule
  localparam int IW = COORD_W + 8;
  localparam int PW = IW + T_W;

  localparam logic signed [PW-1:0] HALF_LO = PW'(1) << (T_FRAC_BITS - 1);
  localparam logic signed [PW-1:0] HALF_HI = PW'(1) << T_FRAC_BITS;
  localparam logic signed [IW-1:0] SAT_HI =
    {{(IW - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
  localparam logic signed [IW-1:0] SAT_LO = ~SAT_HI;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LAST,
    S_M1,
    S_M2,
    S_M3
  } state_t;

  // Multiply by the weight and round half up; half selects the extra halving step
  function automatic logic signed [IW-1:0] mul_rnd(input logic signed [IW-1:0] a,
                                                  input logic [T_FRAC_BITS-1:0] w,
                                                  input logic half);
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] sh;
    prod = a * $signed({1'b0, w});
    if (half) begin
      sh = (prod + HALF_HI) >>> (T_FRAC_BITS + 1);
    end else begin
      sh = (prod + HALF_LO) >>> T_FRAC_BITS;
    end
    return sh[IW-1:0];
  endfunction

  state_t                    state_r;
  logic [COUNT_W-1:0]        count_r;
  logic [1:0]                rd_cnt_r;
  logic [ADDR_W-1:0]         seg_r;
  logic [T_FRAC_BITS-1:0]    w_r;
  logic signed [COORD_W-1:0] pt_r [2][3];
  logic signed [IW-1:0]      a_r [2];
  logic signed [IW-1:0]      b_r [2];
  logic signed [IW-1:0]      v_r [2];
  logic signed [IW-1:0]      p1_r [2];
  logic signed [IW-1:0]      acc_r [2];
  logic                      out_valid_r;
  out_t                      out_r;

  logic                      accept;
  logic                      full;
  logic [COUNT_W-1:0]        n_m1;
  logic [T_W-1:0]            t_cl;
  logic [COUNT_W+T_W-1:0]    pos;
  logic [ADDR_W-1:0]         last_idx;
  logic [COUNT_W-1:0]        seg_ext;
  logic [ADDR_W-1:0]         idx0, idx2, idx3, rd_addr;
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_addr;
  logic [COORD_W-1:0]        rdata [2];
  logic signed [IW-1:0]      c0 [2];
  logic signed [IW-1:0]      c1 [2];
  logic signed [IW-1:0]      c2 [2];
  logic signed [IW-1:0]      c3 [2];
  logic signed [IW-1:0]      res [2];
  logic signed [COORD_W-1:0] res_sat [2];

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count_r == COUNT_W'(MAX_POINTS));

  // Segment position: (count-1) * t, t clamped to one
  assign n_m1 = count_r - COUNT_W'(1);
  assign t_cl = (in_data.t_frac > T_ONE) ? T_ONE : in_data.t_frac;
  assign pos  = n_m1 * t_cl;

  // Neighbor indices, clamped at both ends of the table
  assign last_idx = n_m1[ADDR_W-1:0];
  assign seg_ext  = {1'b0, seg_r};
  assign idx0 = (seg_r == '0) ? '0 : seg_r - ADDR_W'(1);
  assign idx2 = (seg_ext + COUNT_W'(1) >= count_r) ? last_idx : seg_r + ADDR_W'(1);
  assign idx3 = (seg_ext + COUNT_W'(2) >= count_r) ? last_idx : seg_r + ADDR_W'(2);

  always_comb begin
    unique case (rd_cnt_r)
      2'd0: rd_addr = idx0;
      2'd1: rd_addr = seg_r;
      2'd2: rd_addr = idx2;
      default: rd_addr = idx3;
    endcase
  end

  // Memory port: append writes at the fill point while idle, the read sequencer owns it otherwise
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = count_r[ADDR_W-1:0];
    if (state_r == S_IDLE) begin
      ram_we = accept && (in_data.op == OP_APPEND) && !full;
    end else begin
      ram_addr = rd_addr;
    end
  end

  crs_ram #(
    .WIDTH(COORD_W),
    .DEPTH(MAX_POINTS)
  ) u_ram_x (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_data.x_in),
    .rdata(rdata[0])
  );

  crs_ram #(
    .WIDTH(COORD_W),
    .DEPTH(MAX_POINTS)
  ) u_ram_y (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_data.y_in),
    .rdata(rdata[1])
  );

  // Points widened for the doubled Catmull-Rom coefficients; the fourth point comes straight from the memory
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      c0[l] = IW'(pt_r[l][0]);
      c1[l] = IW'(pt_r[l][1]);
      c2[l] = IW'(pt_r[l][2]);
      c3[l] = IW'($signed(rdata[l]));
    end
  end

  // Final Horner step and saturation to the coordinate range
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      res[l] = p1_r[l] + mul_rnd(acc_r[l] + v_r[l], w_r, 1'b1);
      if (res[l] > SAT_HI) begin
        res_sat[l] = SAT_HI[COORD_W-1:0];
      end else if (res[l] < SAT_LO) begin
        res_sat[l] = SAT_LO[COORD_W-1:0];
      end else begin
        res_sat[l] = res[l][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_r.x_out  <= '0;
            out_r.y_out  <= '0;
            out_r.status <= ST_OK;
            if (in_data.op == OP_APPEND) begin
              out_valid_r <= 1'b1;
              if (full) begin
                // drop the point
                out_r.status <= ST_FULL;
              end else begin
                count_r <= count_r + COUNT_W'(1);
              end
            end else if (count_r == '0) begin
              out_valid_r  <= 1'b1;
              out_r.status <= ST_EMPTY;
            end else begin
              seg_r    <= pos[T_FRAC_BITS +: ADDR_W];
              w_r      <= pos[T_FRAC_BITS-1:0];
              rd_cnt_r <= '0;
              state_r  <= S_READ;
            end
          end
        end
        S_READ: begin
          // read data arrives in the cycle after its address
          if (rd_cnt_r != 2'd0) begin
            for (int l = 0; l < 2; l++) begin
              pt_r[l][rd_cnt_r - 2'd1] <= $signed(rdata[l]);
            end
          end
          rd_cnt_r <= rd_cnt_r + 2'd1;
          if (rd_cnt_r == 2'd3) begin
            state_r <= S_LAST;
          end
        end
        S_LAST: begin
          for (int l = 0; l < 2; l++) begin
            a_r[l]  <= 3 * c1[l] - 3 * c2[l] - c0[l] + c3[l];
            b_r[l]  <= 2 * c0[l] - 5 * c1[l] + 4 * c2[l] - c3[l];
            v_r[l]  <= c2[l] - c0[l];
            p1_r[l] <= c1[l];
          end
          state_r <= S_M1;
        end
        S_M1: begin
          for (int l = 0; l < 2; l++) begin
            acc_r[l] <= mul_rnd(a_r[l], w_r, 1'b0);
          end
          state_r <= S_M2;
        end
        S_M2: begin
          for (int l = 0; l < 2; l++) begin
            acc_r[l] <= mul_rnd(acc_r[l] + b_r[l], w_r, 1'b0);
          end
          state_r <= S_M3;
        end
        S_M3: begin
          out_r.x_out  <= res_sat[0];
          out_r.y_out  <= res_sat[1];
          out_r.status <= ST_OK;
          out_valid_r  <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // Reads only touch entries below the fill count
  a_read_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> ({1'b0, rd_addr} < count_r))
    else $error("point read beyond the filled table");

  // An accepted append to a non-full table advances the count by one
  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.op == OP_APPEND && !full) |=>
      (count_r == COUNT_W'($past(count_r) + COUNT_W'(1))))
    else $error("append did not advance the point count");

  // Empty status only while the table is empty
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_EMPTY) |-> (count_r == '0))
    else $error("empty status with points in the table");

  // The last multiply step always delivers an ok result next cycle
  a_eval_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_M3) |=> (out_valid_r && out_r.status == ST_OK && !busy))
    else $error("evaluate finished without a result strobe");
`endif

endmodule

### sim/catmull_rom_spline_evaluator_tb.sv
`timescale 1ns / 100ps

module catmull_rom_spline_evaluator_tb;
  import crs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 850;
  localparam int QUIET_TAIL = 100;
  localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam longint T_ONE = longint'(1) << T_FRAC_BITS;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  catmull_rom_spline_evaluator uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .in_data(in_data),
    .busy(busy),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Synchronous reset, held low at the start and released once.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Commands waiting to be offered, and the results still owed by the block.
  in_t cmd_q[$];
  out_t curve_q[$];

  // Shadow copy of the control point table.
  logic signed [COORD_W-1:0] x_pts[MAX_POINTS];
  logic signed [COORD_W-1:0] y_pts[MAX_POINTS];
  int pts_used = 0;

  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int idle_left = 0;
  int n_stored = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_curve = 0;
  int n_clipped = 0;
  bit accepted;
  out_t want;

  // Round half up: floor((v + 2^(n-1)) / 2^n); >>> on a signed longint floors.
  function automatic longint round_half_up(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // One coordinate through the uniform Catmull-Rom cubic, coefficients doubled so
  // no half is lost, then clip to the signed coordinate range.
  function automatic logic signed [COORD_W-1:0] catmull_coord(longint w, longint p0,
                                                               longint p1, longint p2,
                                                               longint p3);
    longint a, b, v, s1, s2, r;
    a = 3 * p1 - 3 * p2 - p0 + p3;
    b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    v = p2 - p0;
    s1 = round_half_up(a * w, T_FRAC_BITS);
    s2 = round_half_up((s1 + b) * w, T_FRAC_BITS);
    r = p1 + round_half_up((s2 + v) * w, T_FRAC_BITS + 1);
    if (r > COORD_MAX) begin
      n_clipped++;
      r = COORD_MAX;
    end else if (r < COORD_MIN) begin
      n_clipped++;
      r = COORD_MIN;
    end
    return r[COORD_W-1:0];
  endfunction

  // Apply one accepted command to the shadow table and work out the result it owes.
  function automatic out_t table_apply(in_t cmd);
    out_t r;
    longint n, t, p, seg, w;
    int i0, i1, i2, i3;
    r = '0;
    r.status = ST_OK;
    if (cmd.op == OP_APPEND) begin
      if (pts_used >= MAX_POINTS) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        x_pts[pts_used] = cmd.x_in;
        y_pts[pts_used] = cmd.y_in;
        pts_used++;
        n_stored++;
      end
    end else if (pts_used == 0) begin
      r.status = ST_EMPTY;
      n_empty++;
    end else begin
      n = pts_used;
      t = cmd.t_frac;
      // t past 1.0 clamps to 1.0
      if (t > T_ONE) t = T_ONE;
      p = (n - 1) * t;
      seg = p >> T_FRAC_BITS;
      w = p & (T_ONE - 1);
      if (seg > n - 1) seg = n - 1;
      // clamp the neighbors to both ends of the table
      i0 = (seg == 0) ? 0 : int'(seg - 1);
      i1 = int'(seg);
      i2 = (seg > n - 2) ? int'(n - 1) : int'(seg + 1);
      i3 = (seg > n - 3) ? int'(n - 1) : int'(seg + 2);
      r.x_out = catmull_coord(w, x_pts[i0], x_pts[i1], x_pts[i2], x_pts[i3]);
      r.y_out = catmull_coord(w, y_pts[i0], y_pts[i1], y_pts[i2], y_pts[i3]);
      n_curve++;
    end
    return r;
  endfunction

  function automatic in_t make_cmd(op_t op, logic [T_W-1:0] t, logic [COORD_W-1:0] x,
                                   logic [COORD_W-1:0] y);
    in_t c;
    c.op = op;
    c.t_frac = t;
    c.x_in = x;
    c.y_in = y;
    return c;
  endfunction

  // Small coordinates half of the time, with full-range and extreme values mixed in.
  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: return COORD_MAX[COORD_W-1:0];
      3: return COORD_MIN[COORD_W-1:0];
      default: return $urandom_range(0, 2 ** 22) - 2 ** 21;
    endcase
  endfunction

  function automatic logic [T_W-1:0] rand_t();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return T_ONE[T_W-1:0];
      2: return T_W'($urandom_range(T_ONE + 1, 2 ** T_W - 1));
      default: return T_W'($urandom_range(0, T_ONE - 1));
    endcase
  endfunction

  // Gaps come in blocks, leaving quiet stretches, and stop near the end of the run.
  function automatic bit gaps_allowed();
    return (sent % 128) < 80 && cmd_q.size() > QUIET_TAIL;
  endfunction

  // Driver: offer commands from cmd_q, predict each one at its transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        curve_q.push_back(table_apply(in_data));
        sent++;
      end
      if (start && !accepted) begin
        // occasionally withdraw an offer while the block is busy, so that
        // gaps also land late in an evaluation
        if (gaps_allowed() && $urandom_range(0, 7) == 0) begin
          cmd_q.push_front(in_data);
          start <= 1'b0;
          idle_left = $urandom_range(0, 2);
        end
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (cmd_q.size() == 0) begin
        start <= 1'b0;
      end else if (gaps_allowed() && $urandom_range(0, 3) == 0) begin
        idle_left = $urandom_range(0, 2);
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        in_data <= cmd_q.pop_front();
      end
    end
  end

  task automatic check_field(input string name, input logic [COORD_W-1:0] exp_v,
                             input logic [COORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Monitor: every strobed result must match the oldest owed result.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (curve_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed, expected none actual %h", $time, out_data);
      end else begin
        want = curve_q.pop_front();
        check_field("x_out", want.x_out, out_data.x_out);
        check_field("y_out", want.y_out, out_data.y_out);
        check_field("status", COORD_W'(want.status), COORD_W'(out_data.status));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results owed", $time, curve_q.size());
      $display("catmull_rom_spline_evaluator_tb failed");
      $finish;
    end
  end

  initial begin
    int gen_pts;
    gen_pts = 0;
    // Empty table, including t past one.
    cmd_q.push_back(make_cmd(OP_EVAL, '0, 32'h1234_5678, 32'h8765_4321));
    cmd_q.push_back(make_cmd(OP_EVAL, '1, '0, '0));
    // Single point: every neighbor is point 0.
    cmd_q.push_back(make_cmd(OP_APPEND, '1, 32'h7FFF_FFFF, 32'h8000_0000));
    cmd_q.push_back(make_cmd(OP_EVAL, '0, '0, '0));
    cmd_q.push_back(make_cmd(OP_EVAL, T_ONE[T_W-1:0], '0, '0));
    cmd_q.push_back(make_cmd(OP_EVAL, '1, '1, '1));
    // Two points, clamping on both sides.
    cmd_q.push_back(make_cmd(OP_APPEND, '0, 32'h8000_0000, 32'h7FFF_FFFF));
    cmd_q.push_back(make_cmd(OP_EVAL, 17'd32768, '0, '0));
    cmd_q.push_back(make_cmd(OP_EVAL, 17'd1, '0, '0));
    cmd_q.push_back(make_cmd(OP_EVAL, 17'd65535, '0, '0));
    // Alternating extremes drive the cubic into clipping.
    cmd_q.push_back(make_cmd(OP_APPEND, '0, 32'h7FFF_FFFF, 32'h8000_0000));
    cmd_q.push_back(make_cmd(OP_APPEND, '0, 32'h8000_0000, 32'h7FFF_FFFF));
    cmd_q.push_back(make_cmd(OP_EVAL, 17'd21845, '0, '0));
    cmd_q.push_back(make_cmd(OP_EVAL, 17'd43690, '0, '0));
    cmd_q.push_back(make_cmd(OP_EVAL, 17'd50000, '0, '0));
    cmd_q.push_back(make_cmd(OP_EVAL, 17'd100000, '0, '0));
    // Small values around zero.
    cmd_q.push_back(make_cmd(OP_APPEND, '0, '0, '0));
    cmd_q.push_back(make_cmd(OP_APPEND, '0, 32'hFFFF_FFFF, 32'h0000_0001));
    cmd_q.push_back(make_cmd(OP_EVAL, 17'd65535, '0, '0));
    cmd_q.push_back(make_cmd(OP_EVAL, 17'd49152, '0, '0));
    cmd_q.push_back(make_cmd(OP_EVAL, T_ONE[T_W-1:0], '0, '0));
    gen_pts = 6;
    // Random part: the table fills about four fifths of the way through,
    // after which appends are refused as full.
    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < ((gen_pts < MAX_POINTS) ? 36 : 25)) begin
        cmd_q.push_back(make_cmd(OP_APPEND, T_W'($urandom), rand_coord(), rand_coord()));
        if (gen_pts < MAX_POINTS) gen_pts++;
      end else begin
        cmd_q.push_back(make_cmd(OP_EVAL, rand_t(), $urandom, $urandom));
      end
    end

    // Drain: all commands transferred and every owed result seen.
    do @(posedge clk); while (cmd_q.size() != 0 || start || curve_q.size() != 0);
    // Allow a stray result to surface.
    repeat (16) @(posedge clk);

    $display("Covered %0d commands: %0d points stored, %0d appends refused as full,",
             sent, n_stored, n_full);
    $display("%0d evaluations on the empty table, %0d curve evaluations, %0d clipped coords.",
             n_empty, n_curve, n_clipped);
    if (errors == 0) begin
      $display("catmull_rom_spline_evaluator_tb passed");
    end else begin
      $display("catmull_rom_spline_evaluator_tb failed");
    end
    $finish;
  end

endmodule
